@@ hdl/mrd_pkg.sv @@
`timescale 1ns / 1ps

package mrd_pkg;

  localparam int unsigned MIN_FRAME_BYTES = 21;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Register word index, taken from paddr[2].
  localparam logic REG_SLAVE_ADDRESS = 1'b0;
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

  // Frame byte positions, counted from zero.
  localparam logic [7:0] POS_VOLTAGE_FIRST = 8'd3;
  localparam logic [7:0] POS_VOLTAGE_LAST  = 8'd6;
  localparam logic [7:0] POS_CURRENT_FIRST = 8'd7;
  localparam logic [7:0] POS_CURRENT_LAST  = 8'd10;
  localparam logic [7:0] POS_POWER_FIRST   = 8'd11;
  localparam logic [7:0] POS_POWER_LAST    = 8'd14;
  localparam logic [7:0] POS_ENERGY_FIRST  = 8'd15;
  localparam logic [7:0] POS_ENERGY_LAST   = 8'd18;
  localparam logic [7:0] POS_MAX           = 8'd255;

  localparam int unsigned RESULT_W = 140;
  localparam int unsigned M_TDATA_W = 144;

  typedef struct packed {
    logic [31:0] energy_raw;
    logic [31:0] power_raw;
    logic [31:0] current_raw;
    logic [31:0] voltage_raw;
    logic [7:0]  byte_total;
    logic        length_ok;
    logic        crc_match;
    logic        address_match;
    logic        frame_good;
  } result_t;

endpackage

@@ hdl/modbus_rtu_response_decoder_top.sv @@
`timescale 1ns / 1ps

// Checks Modbus RTU read-registers replies streamed one byte per transfer,
// with tlast on the final byte. Each byte passes an input register and then
// the CRC-16/MODBUS update and field capture, so a byte can be taken every
// cycle unless a final byte is held back; the final byte of a frame yields
// one registered result transfer holding the address, CRC and length checks,
// the byte count (saturating at 255) and the four big-endian 32-bit values
// from bytes 3-18. A byte that is not the final one never holds up the input
// by itself; a final byte waits in the input register, and stalls the
// transfers behind it, only while the previous result has not been taken.
// The expected slave address is register 0 (byte address 0), reset value 1.
module modbus_rtu_response_decoder_top
  import mrd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  s_tlast,   // end_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [0] frame_good, [1] address_match, [2] crc_match, [3] length_ok,
  // [11:4] byte_total, [43:12] voltage_raw, [75:44] current_raw,
  // [107:76] power_raw, [139:108] energy_raw, [143:140] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  logic [7:0] slave_address;
  result_t    result;
  result_t    out_result;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDRESS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SLAVE_ADDRESS) begin
      slave_address <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {24'd0, slave_address} : '0;

  // A held byte moves on unless it closes a frame and the result slot is busy.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  mrd_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .rx_byte       (in_byte),
    .end_of_frame  (in_last),
    .slave_address (slave_address),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, out_result};

endmodule

@@ hdl/mrd_crc.sv @@
`timescale 1ns / 1ps

module mrd_crc
  import mrd_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  // Reflected CRC-16, eight bit steps unrolled for one byte.
  always_comb begin
    logic [15:0] acc;
    acc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ CRC_POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_out = acc;
  end

endmodule

@@ hdl/mrd_frame.sv @@
`timescale 1ns / 1ps

module mrd_frame
  import mrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] rx_byte,
  input  logic       end_of_frame,
  input  logic [7:0] slave_address,
  output result_t    result
);

  logic [15:0] crc_accum;
  logic [7:0]  byte_position;
  logic        address_seen_ok;
  logic [31:0] voltage_shift;
  logic [31:0] current_shift;
  logic [31:0] power_shift;
  logic [31:0] energy_shift;

  logic [15:0] crc_next;
  logic [7:0]  byte_position_next;
  logic        address_seen_ok_next;
  logic [31:0] voltage_shift_next;
  logic [31:0] current_shift_next;
  logic [31:0] power_shift_next;
  logic [31:0] energy_shift_next;

  mrd_crc u_crc (
    .crc_in  (crc_accum),
    .data    (rx_byte),
    .crc_out (crc_next)
  );

  always_comb begin
    address_seen_ok_next = (byte_position == 8'd0) ? (rx_byte == slave_address)
                                                   : address_seen_ok;
    voltage_shift_next = voltage_shift;
    current_shift_next = current_shift;
    power_shift_next   = power_shift;
    energy_shift_next  = energy_shift;
    if (byte_position >= POS_VOLTAGE_FIRST && byte_position <= POS_VOLTAGE_LAST) begin
      voltage_shift_next = {voltage_shift[23:0], rx_byte};
    end else if (byte_position >= POS_CURRENT_FIRST && byte_position <= POS_CURRENT_LAST) begin
      current_shift_next = {current_shift[23:0], rx_byte};
    end else if (byte_position >= POS_POWER_FIRST && byte_position <= POS_POWER_LAST) begin
      power_shift_next = {power_shift[23:0], rx_byte};
    end else if (byte_position >= POS_ENERGY_FIRST && byte_position <= POS_ENERGY_LAST) begin
      energy_shift_next = {energy_shift[23:0], rx_byte};
    end
    byte_position_next = (byte_position == POS_MAX) ? POS_MAX : byte_position + 8'd1;
  end

  always_comb begin
    result.address_match = address_seen_ok_next;
    result.crc_match     = (crc_next == 16'h0000);
    result.length_ok     = (byte_position_next >= 8'(MIN_FRAME_BYTES));
    result.frame_good    = result.address_match & result.crc_match & result.length_ok;
    result.byte_total    = byte_position_next;
    result.voltage_raw   = voltage_shift_next;
    result.current_raw   = current_shift_next;
    result.power_raw     = power_shift_next;
    result.energy_raw    = energy_shift_next;
  end

  // The last byte of a frame clears the frame state for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_accum       <= CRC_INIT;
      byte_position   <= 8'd0;
      address_seen_ok <= 1'b0;
      voltage_shift   <= 32'd0;
      current_shift   <= 32'd0;
      power_shift     <= 32'd0;
      energy_shift    <= 32'd0;
    end else if (advance) begin
      if (end_of_frame) begin
        crc_accum       <= CRC_INIT;
        byte_position   <= 8'd0;
        address_seen_ok <= 1'b0;
        voltage_shift   <= 32'd0;
        current_shift   <= 32'd0;
        power_shift     <= 32'd0;
        energy_shift    <= 32'd0;
      end else begin
        crc_accum       <= crc_next;
        byte_position   <= byte_position_next;
        address_seen_ok <= address_seen_ok_next;
        voltage_shift   <= voltage_shift_next;
        current_shift   <= current_shift_next;
        power_shift     <= power_shift_next;
        energy_shift    <= energy_shift_next;
      end
    end
  end

endmodule

@@ hdl/mrd_checker.sv @@
`timescale 1ns / 1ps

module mrd_checker
  import mrd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_TDATA_W-1:0]  m_tdata
);

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[0] == (m_tdata[1] & m_tdata[2] & m_tdata[3]))
    else $error("frame_good disagrees with the individual checks");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3] == (m_tdata[11:4] >= 8'(MIN_FRAME_BYTES)))
    else $error("length_ok disagrees with byte_total");

  // A result needs at least one accepted byte, so none appears right after reset.
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[11:4] != 8'd0)
    else $error("result with zero byte count");

endmodule

bind modbus_rtu_response_decoder_top mrd_checker u_mrd_checker (.*);

@@ bench/tb_modbus_rtu_response_decoder_top.sv @@
`timescale 1ns / 1ps

module tb_modbus_rtu_response_decoder_top;
  import mrd_pkg::*;

  localparam logic [APB_ADDR_W-1:0] SLAVE_ADDRESS_PADDR = {REG_SLAVE_ADDRESS, 2'b00};
  // Register index 1 is not mapped, so a write there must change nothing.
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_PADDR = 3'd4;
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int MIN_BYTES = 600;
  localparam int MIN_FRAMES = 30;

  typedef struct {
    logic [15:0] crc;
    logic [7:0]  pos;
    logic        addr_ok;
    logic [31:0] volt;
    logic [31:0] curr;
    logic [31:0] pwr;
    logic [31:0] enrg;
  } frame_state_t;

  // flags are {frame_good, address_match, crc_match, length_ok}.
  typedef struct {
    logic [7:0]  addr;
    int          len;
    bit          rand_fill;
    logic [7:0]  fill;
    bit          crc_ok;
    bit          mid_write;
    bit          typed;
    logic [3:0]  flags;
    logic [7:0]  total;
    logic [31:0] value;
  } frame_case_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  frame_state_t frame_st;
  logic [7:0]   slave_addr_copy;
  result_t      expected_replies[$];
  int           mismatches;
  int           bytes_sent;
  int           frames_sent;
  bit           send_steady;
  bit           recv_steady;
  bit           rush_sender;
  bit           hold_replies;
  frame_case_t  directed_frames[13];

  modbus_rtu_response_decoder_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    frame_st.crc = CRC_INIT;
    frame_st.pos = '0;
    frame_st.addr_ok = 1'b0;
    frame_st.volt = '0;
    frame_st.curr = '0;
    frame_st.pwr = '0;
    frame_st.enrg = '0;
  endfunction

  // Advances the frame state by one byte and, on the final byte, returns the reply.
  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      output bit has_reply, output result_t reply);
    logic [7:0] total;
    has_reply = 1'b0;
    reply = '0;
    if (frame_st.pos == 8'd0) frame_st.addr_ok = (b == slave_addr_copy);
    frame_st.crc = crc16_byte(frame_st.crc, b);
    if (frame_st.pos >= POS_VOLTAGE_FIRST && frame_st.pos <= POS_VOLTAGE_LAST)
      frame_st.volt = {frame_st.volt[23:0], b};
    else if (frame_st.pos >= POS_CURRENT_FIRST && frame_st.pos <= POS_CURRENT_LAST)
      frame_st.curr = {frame_st.curr[23:0], b};
    else if (frame_st.pos >= POS_POWER_FIRST && frame_st.pos <= POS_POWER_LAST)
      frame_st.pwr = {frame_st.pwr[23:0], b};
    else if (frame_st.pos >= POS_ENERGY_FIRST && frame_st.pos <= POS_ENERGY_LAST)
      frame_st.enrg = {frame_st.enrg[23:0], b};
    total = (frame_st.pos == POS_MAX) ? POS_MAX : frame_st.pos + 8'd1;
    frame_st.pos = total;
    if (last) begin
      has_reply = 1'b1;
      reply.address_match = frame_st.addr_ok;
      reply.crc_match = (frame_st.crc == 16'h0000);
      reply.length_ok = (total >= MIN_FRAME_BYTES);
      reply.frame_good = reply.address_match & reply.crc_match & reply.length_ok;
      reply.byte_total = total;
      reply.voltage_raw = frame_st.volt;
      reply.current_raw = frame_st.curr;
      reply.power_raw = frame_st.pwr;
      reply.energy_raw = frame_st.enrg;
      clear_frame_state();
    end
  endfunction

  function automatic int sender_gap();
    if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
    if (send_steady || rush_sender) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic int receiver_gap();
    if ($urandom_range(0, 29) == 0) recv_steady = !recv_steady;
    if (recv_steady) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endfunction

  // Builds a read-registers reply: address, function code, byte count, data, CRC low first.
  function automatic void build_frame(input logic [7:0] addr, input int len, input bit rand_fill,
                                      input logic [7:0] fill, input bit crc_ok,
                                      ref logic [7:0] q[$]);
    logic [15:0] crc;
    logic [7:0]  b;
    int          payload;
    q.delete();
    payload = (len < 3) ? len : len - 2;
    crc = CRC_INIT;
    for (int i = 0; i < payload; i++) begin
      if (i == 0) b = addr;
      else if (rand_fill) b = 8'($urandom);
      else if (i == 1 && len >= 3) b = FC_READ_HOLDING;
      else if (i == 2 && len >= 3) b = 8'(len - 5);
      else b = fill;
      q.push_back(b);
      crc = crc16_byte(crc, b);
    end
    if (len >= 3) begin
      if (!crc_ok) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      q.push_back(crc[7:0]);
      q.push_back(crc[15:8]);
    end
  endfunction

  function automatic void random_frame(ref logic [7:0] q[$]);
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 40) : $urandom_range(21, 28);
    if (pick < 65) begin
      build_frame(slave_addr_copy, len, 1'b1, 8'h00, 1'b1, q);
    end else if (pick < 75) begin
      build_frame(slave_addr_copy ^ 8'($urandom_range(1, 255)), len, 1'b1, 8'h00, 1'b1, q);
    end else if (pick < 85) begin
      build_frame(slave_addr_copy, len, 1'b1, 8'h00, 1'b0, q);
    end else if (pick < 93) begin
      build_frame(slave_addr_copy, $urandom_range(1, 20), 1'b1, 8'h00, 1'b1, q);
    end else if (pick < 95) begin
      build_frame(slave_addr_copy, $urandom_range(200, 300), 1'b1, 8'h00, 1'b1, q);
    end else begin
      q.delete();
      len = $urandom_range(1, 30);
      repeat (len) q.push_back(8'($urandom));
    end
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last,
                           output bit has_reply, output result_t reply);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, last, has_reply, reply);
    bytes_sent++;
    if (last) frames_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [31:0] d);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = a;
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic check_slave_address();
    logic [31:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = SLAVE_ADDRESS_PADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    check_field("slave_address", {24'h0, slave_addr_copy}, {24'h0, rd[7:0]});
  endtask

  task automatic set_slave_address(input logic [7:0] v);
    apb_write(SLAVE_ADDRESS_PADDR, {24'h0, v});
    slave_addr_copy = v;
    check_slave_address();
  endtask

  task automatic send_frame(ref logic [7:0] q[$], input bit use_typed, input result_t typed_reply,
                            input bit mid_write, input logic [7:0] mid_addr);
    bit      has;
    result_t r;
    for (int i = 0; i < q.size(); i++) begin
      push_byte(q[i], i == q.size() - 1, has, r);
      if (has) expected_replies.push_back(use_typed ? typed_reply : r);
      // The address was already compared on the first byte; a new value must not matter.
      if (mid_write && i == 0 && q.size() > 1) begin
        wait_drained();
        set_slave_address(mid_addr);
      end
    end
  endtask

  initial begin
    int      gap;
    result_t got;
    result_t want;
    m_tready = 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    forever begin
      if (hold_replies) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_replies = 1'b0;
      end
      gap = receiver_gap();
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = result_t'(m_tdata[RESULT_W-1:0]);
      if (expected_replies.size() == 0) begin
        $error("reply transfer with nothing pending");
        mismatches++;
      end else begin
        want = expected_replies.pop_front();
        check_field("frame_good", 32'(want.frame_good), 32'(got.frame_good));
        check_field("address_match", 32'(want.address_match), 32'(got.address_match));
        check_field("crc_match", 32'(want.crc_match), 32'(got.crc_match));
        check_field("length_ok", 32'(want.length_ok), 32'(got.length_ok));
        check_field("byte_total", 32'(want.byte_total), 32'(got.byte_total));
        check_field("voltage_raw", want.voltage_raw, got.voltage_raw);
        check_field("current_raw", want.current_raw, got.current_raw);
        check_field("power_raw", want.power_raw, got.power_raw);
        check_field("energy_raw", want.energy_raw, got.energy_raw);
      end
      @(negedge clk);
    end
  end

  initial begin
    logic [7:0]  frame_q[$];
    result_t     typed_r;
    frame_case_t fc;
    int          phase;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    bytes_sent = 0;
    frames_sent = 0;
    send_steady = 1'b0;
    recv_steady = 1'b0;
    rush_sender = 1'b0;
    hold_replies = 1'b0;
    slave_addr_copy = SLAVE_ADDRESS_RESET;
    clear_frame_state();
    directed_frames = '{
      '{8'h01, 21,  0, 8'h00, 1, 0, 1, 4'b1111, 8'd21,  32'h0000_0000},
      '{8'h01, 21,  0, 8'hFF, 1, 0, 1, 4'b1111, 8'd21,  32'hFFFF_FFFF},
      '{8'h02, 21,  0, 8'h00, 1, 0, 1, 4'b0011, 8'd21,  32'h0000_0000},
      '{8'h01, 21,  0, 8'hFF, 0, 0, 1, 4'b0101, 8'd21,  32'hFFFF_FFFF},
      '{8'h01, 20,  1, 8'h00, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h01, 1,   0, 8'h00, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h00, 1,   0, 8'h00, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h01, 2,   0, 8'hFF, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h01, 7,   1, 8'h00, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h01, 256, 0, 8'hAA, 1, 0, 1, 4'b1111, 8'd255, 32'hAAAA_AAAA},
      '{8'h01, 21,  0, 8'hFF, 1, 1, 1, 4'b1111, 8'd21,  32'hFFFF_FFFF},
      '{8'h01, 24,  1, 8'h00, 1, 0, 0, 4'b0000, 8'd0,   32'h0},
      '{8'h01, 21,  1, 8'h00, 0, 0, 0, 4'b0000, 8'd0,   32'h0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_slave_address();

    foreach (directed_frames[i]) begin
      fc = directed_frames[i];
      build_frame(fc.addr, fc.len, fc.rand_fill, fc.fill, fc.crc_ok, frame_q);
      typed_r = '0;
      {typed_r.frame_good, typed_r.address_match, typed_r.crc_match, typed_r.length_ok} =
        fc.flags;
      typed_r.byte_total = fc.total;
      typed_r.voltage_raw = fc.value;
      typed_r.current_raw = fc.value;
      typed_r.power_raw = fc.value;
      typed_r.energy_raw = fc.value;
      send_frame(frame_q, fc.typed, typed_r, fc.mid_write, 8'h77);
      if (fc.mid_write) begin
        wait_drained();
        set_slave_address(SLAVE_ADDRESS_RESET);
      end
    end

    phase = 0;
    while (phase < 4 || bytes_sent < MIN_BYTES || frames_sent < MIN_FRAMES) begin
      wait_drained();
      case (phase)
        0: set_slave_address(8'h00);
        1: begin
          apb_write(UNMAPPED_PADDR, $urandom);
          check_slave_address();
          set_slave_address(8'hFF);
        end
        default: set_slave_address(8'($urandom_range(0, 255)));
      endcase
      if (phase == 2) begin
        // Replies are held back while short frames keep coming, so the block backs up.
        hold_replies = 1'b1;
        rush_sender = 1'b1;
        repeat (12) begin
          build_frame(slave_addr_copy, $urandom_range(1, 3), 1'b1, 8'h00, 1'b1, frame_q);
          send_frame(frame_q, 1'b0, typed_r, 1'b0, 8'h00);
        end
        rush_sender = 1'b0;
      end
      repeat (2) begin
        random_frame(frame_q);
        send_frame(frame_q, 1'b0, typed_r, 1'b0, 8'h00);
      end
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mrd_pkg.sv
hdl/mrd_crc.sv
hdl/mrd_frame.sv
hdl/modbus_rtu_response_decoder_top.sv
hdl/mrd_checker.sv
bench/tb_modbus_rtu_response_decoder_top.sv
